// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the text-to-integer block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define BNTOI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define BNTOI_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  `BNTOI_ASSERT(lbl, clk, rst_n, (expr), msg)

`endif

// File: sv/bntoi_pkg.sv
// ----------------------------------------------------------------------------
// bntoi_pkg
// Types and constants shared by the text-to-integer front end, queue and back end.
// ----------------------------------------------------------------------------
package bntoi_pkg;

  localparam int unsigned MAX_SYMBOLS = 16;
  localparam int unsigned LenW        = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned DigW        = $clog2(MAX_SYMBOLS);
  localparam int unsigned AlphaW      = 8 * MAX_SYMBOLS;

  // Queue depth between front and back end; must be a power of two.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCntW  = $clog2(QDEPTH + 1);

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  localparam logic [CfgIdxW-1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  localparam logic [4:0]  BASE_LENGTH_RST  = 5'd10;
  localparam logic [63:0] SYMBOLS_LOW_RST  = 64'h3736353433323130;
  localparam logic [63:0] SYMBOLS_HIGH_RST = 64'h0000000000003938;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // One classified character as it travels from the front to the back end.
  typedef struct packed {
    logic            last;
    logic            is_space;
    logic            is_plus;
    logic            is_minus;
    logic            hit;
    logic [DigW-1:0] digit;
    logic [LenW-1:0] radix;
  } token_t;

  typedef enum logic [2:0] {
    PH_SKIP    = 3'b001,
    PH_DIGITS  = 3'b010,
    PH_STOPPED = 3'b100
  } phase_e;

endpackage

// File: sv/bntoi_front.sv
// ----------------------------------------------------------------------------
// bntoi_front
// Holds the alphabet registers and classifies each incoming character.
// ----------------------------------------------------------------------------
module bntoi_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bntoi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bntoi_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [7:0]                    ch_i,
  input  logic                          last_i,
  output bntoi_pkg::token_t             token_o
);
  import bntoi_pkg::*;

  logic [4:0]        base_length_q;
  logic [63:0]       symbols_low_q;
  logic [63:0]       symbols_high_q;
  logic [AlphaW-1:0] alphabet;
  logic [LenW-1:0]   radix;
  logic              hit;
  logic [DigW-1:0]   digit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_length_q  <= BASE_LENGTH_RST;
      symbols_low_q  <= SYMBOLS_LOW_RST;
      symbols_high_q <= SYMBOLS_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BASE_LENGTH:  base_length_q  <= cfg_data_i[4:0];
        CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_data_i;
        CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign alphabet = {symbols_high_q, symbols_low_q};
  assign radix = (base_length_q > LenW'(MAX_SYMBOLS)) ? LenW'(MAX_SYMBOLS) : base_length_q;

  // Parallel compare against every symbol; scanning downward leaves the lowest match.
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (alphabet[8*i +: 8] == ch_i && LenW'(i) < radix) begin
        hit   = 1'b1;
        digit = DigW'(i);
      end
    end
  end

  always_comb begin
    token_o.last     = last_i;
    token_o.is_space = (ch_i == CH_SPACE) || (ch_i == CH_TAB) || (ch_i == CH_CR) ||
                       (ch_i == CH_LF) || (ch_i == CH_VT) || (ch_i == CH_FF);
    token_o.is_plus  = (ch_i == CH_PLUS);
    token_o.is_minus = (ch_i == CH_MINUS);
    token_o.hit      = hit;
    token_o.digit    = digit;
    token_o.radix    = radix;
  end

endmodule

// File: sv/bntoi_queue.sv
// ----------------------------------------------------------------------------
// bntoi_queue
// Short first-word-fall-through queue of classified characters.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bntoi_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bntoi_pkg::token_t token_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output bntoi_pkg::token_t token_o
);
  import bntoi_pkg::*;

  token_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q;
  logic [QAW-1:0]   rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic [QCntW-1:0] count_d;
  logic             push;
  logic             pop;

  assign full_o  = (count_q == QCntW'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign push    = push_i && !full_o;
  assign pop     = pop_i && valid_o;
  assign token_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      count_q <= count_d;
    end
  end

  `BNTOI_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= QCntW'(QDEPTH), "queue overfilled")
  `BNTOI_ASSERT(a_count_track, clk_i, rst_ni, push && !pop |=> count_q == $past(count_q) + QCntW'(1), "queue count lost a word")

endmodule

// File: sv/bntoi_back.sv
// ----------------------------------------------------------------------------
// bntoi_back
// Parse state machine, multiply-add accumulator and result output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bntoi_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  bntoi_pkg::token_t  token_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_o,
  output logic               stopped_o
);
  import bntoi_pkg::*;

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] value_q;
  logic        stopped_q;
  logic        out_free;
  logic        emit;
  logic [31:0] prod;

  // The result register can take a new word when it is empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = valid_i && (!token_i.last || out_free);
  assign emit     = pop_o && token_i.last;
  assign prod     = acc_q * 32'(token_i.radix);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (pop_o) begin
      if (token_i.last) begin
        phase_d = PH_SKIP;
        neg_d   = 1'b0;
        acc_d   = '0;
      end else if (phase_q == PH_STOPPED) begin
        phase_d = PH_STOPPED;
      end else if (phase_q == PH_SKIP && token_i.is_space) begin
        phase_d = PH_SKIP;
      end else if (token_i.is_plus || token_i.is_minus) begin
        if (phase_q == PH_SKIP) begin
          neg_d   = token_i.is_minus;
          phase_d = PH_DIGITS;
        end else begin
          phase_d = PH_STOPPED;
        end
      end else if (token_i.hit) begin
        acc_d   = prod + 32'(token_i.digit);
        phase_d = PH_DIGITS;
      end else begin
        phase_d = PH_STOPPED;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      value_q   <= neg_q ? (32'd0 - acc_q) : acc_q;
      stopped_q <= (phase_q == PH_STOPPED);
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign stopped_o   = stopped_q;

  `BNTOI_ASSERT(a_clear_after_end, clk_i, rst_ni, emit |=> phase_q == PH_SKIP && acc_q == '0 && !neg_q, "state not cleared after end marker")
  `BNTOI_ASSERT_ALWAYS(a_no_overwrite, clk_i, rst_ni, !(emit && out_valid_q && out_stall_i), "pending result overwritten")

endmodule

// File: sv/base_n_text_to_integer_core.sv
// ----------------------------------------------------------------------------
// base_n_text_to_integer_core
// Text-to-integer converter with a configurable alphabet of up to 16 digits.
// ----------------------------------------------------------------------------
// Characters enter on the input channel (in_valid_i / in_stall_o), one word per
// cycle, with last_i set on the end marker, whose character is ignored. Leading
// whitespace is skipped, one sign is taken, then each alphabet symbol is folded
// in as acc * length + index. A later sign or an unknown character stops the
// parse. Only the end marker produces an output word (value_o, stopped_o) on the
// out_valid_o / out_stall_i channel; the block then clears for the next string.
// Throughput is one character per cycle while the input is not stalled, set by
// the single multiply-add in the back end. The result of an end marker passes
// through the queue and then the result register before it is valid on the
// output. A two-entry queue separates the classifying front end from the
// back end, so the input keeps flowing while a result waits; a stalled result
// holds the back end only when another end marker reaches it, and the input
// stalls once the queue is full. Registers are written on the cfg channel,
// which is always ready; writes should only happen while the block is idle.
// Reset restores base length 10 with the alphabet "0123456789" and clears all
// parse state.
// ----------------------------------------------------------------------------
module base_n_text_to_integer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bntoi_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bntoi_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    ch_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            value_o,
  output logic                          stopped_o
);
  import bntoi_pkg::*;

  token_t front_token;
  token_t queue_token;
  logic   queue_full;
  logic   queue_valid;
  logic   queue_pop;

  assign in_stall_o = queue_full;

  bntoi_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ch_i        (ch_i),
    .last_i      (last_i),
    .token_o     (front_token)
  );

  bntoi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .token_i (front_token),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (queue_pop),
    .token_o (queue_token)
  );

  bntoi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .token_i     (queue_token),
    .pop_o       (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .stopped_o   (stopped_o)
  );

endmodule
